// ----- hdl/ssi_pkg.sv -----
`timescale 1ns / 1ps

package ssi_pkg;

  // Coordinate width actually used: low COORD_BITS of each field, sign-extended
  localparam int COORD_BITS = 32;
  localparam int FIELD_W    = 32;

  localparam int DW  = COORD_BITS + 1;        // edge vector component
  localparam int PW  = 2 * DW;                // product of two components
  localparam int CW  = 2 * COORD_BITS + 2;    // cross product, signed
  localparam int MW  = 2 * COORD_BITS + 1;    // cross product magnitude
  localparam int SL  = COORD_BITS + 1;        // low slice of |s| for the split multiply
  localparam int SH  = MW - SL;               // high slice of |s|
  localparam int NW  = COORD_BITS + MW;       // lerp numerator

  localparam int DIV_STAGES = COORD_BITS;     // one quotient bit per stage
  localparam int RES_LAT    = DIV_STAGES + 7; // accept edge to result edge

  typedef struct packed {
    logic signed [FIELD_W-1:0] p0_x;
    logic signed [FIELD_W-1:0] p0_y;
    logic signed [FIELD_W-1:0] p1_x;
    logic signed [FIELD_W-1:0] p1_y;
    logic signed [FIELD_W-1:0] q0_x;
    logic signed [FIELD_W-1:0] q0_y;
    logic signed [FIELD_W-1:0] q1_x;
    logic signed [FIELD_W-1:0] q1_y;
  } seg_t;

  typedef struct packed {
    logic                      hit;
    logic signed [FIELD_W-1:0] point_x;
    logic signed [FIELD_W-1:0] point_y;
  } res_t;

endpackage

// ----- hdl/ssi_div.sv -----
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
// Valid only when num_i < den_i << COORD_BITS.
module ssi_div (
  input  logic                            clk_i,
  input  logic [ssi_pkg::NW-1:0]          num_i,
  input  logic [ssi_pkg::MW-1:0]          den_i,
  output logic [ssi_pkg::COORD_BITS-1:0]  quo_o
);

  localparam int CB = ssi_pkg::COORD_BITS;
  localparam int MW = ssi_pkg::MW;

  logic [MW-1:0] rem_q [ssi_pkg::DIV_STAGES];
  logic [MW-1:0] den_q [ssi_pkg::DIV_STAGES];
  logic [CB-1:0] low_q [ssi_pkg::DIV_STAGES];
  logic [CB-1:0] quo_q [ssi_pkg::DIV_STAGES];

  for (genvar k = 0; k < ssi_pkg::DIV_STAGES; k++) begin : g_stage
    logic [MW-1:0] rem_in;
    logic [MW-1:0] den_in;
    logic [CB-1:0] low_in;
    logic [CB-1:0] quo_in;
    logic [MW:0]   trial;
    logic [MW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i[ssi_pkg::NW-1:CB];
      assign den_in = den_i;
      assign low_in = num_i[CB-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = {rem_in, low_in[CB-1]};
    assign ge    = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? diff[MW-1:0] : trial[MW-1:0];
      den_q[k] <= den_in;
      low_q[k] <= {low_in[CB-2:0], 1'b0};
      quo_q[k] <= {quo_in[CB-2:0], ge};
    end
  end

  assign quo_o = quo_q[ssi_pkg::DIV_STAGES-1];

endmodule

// ----- hdl/segment_segment_intersect.sv -----
`timescale 1ns / 1ps

// Each accepted word runs through the arithmetic stages, the divider and the output
//   register, and done_o marks its result word as it leaves that register.
// Throughput: one segment pair per cycle; busy_o stays low and start_i may be held.
// The 32-stage restoring divider (one quotient bit per stage) sets the depth.
// Reset (rst_ni low, asynchronous) clears all valid bits; done_o is low after it.
// Results cannot be held off: done_o marks each word for exactly one cycle.
module segment_segment_intersect (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ssi_pkg::seg_t seg_i,
  output logic          busy_o,
  output logic          done_o,
  output ssi_pkg::res_t result_o
);

  localparam int CB = ssi_pkg::COORD_BITS;
  localparam int DW = ssi_pkg::DW;
  localparam int PW = ssi_pkg::PW;
  localparam int CW = ssi_pkg::CW;
  localparam int MW = ssi_pkg::MW;
  localparam int SL = ssi_pkg::SL;
  localparam int SH = ssi_pkg::SH;
  localparam int NW = ssi_pkg::NW;

  // sideband that rides alongside the divider
  typedef struct packed {
    logic                 hit;
    logic                 neg_x;
    logic                 neg_y;
    logic [CB-1:0]        base_x;
    logic [CB-1:0]        base_y;
  } side_t;

  // the pipe never stalls, so nothing is refused
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // valid bits for stages 1 to 6
  logic [5:0] vld_q;

  // ---------------------------------------------------------------------------
  // Stage 1: narrow to COORD_BITS, form d1 = P1-P0, d2 = Q1-Q0, e = Q0-P0
  // ---------------------------------------------------------------------------
  logic signed [CB-1:0] p0x, p0y, p1x, p1y, q0x, q0y, q1x, q1y;
  assign p0x = signed'(seg_i.p0_x[CB-1:0]);
  assign p0y = signed'(seg_i.p0_y[CB-1:0]);
  assign p1x = signed'(seg_i.p1_x[CB-1:0]);
  assign p1y = signed'(seg_i.p1_y[CB-1:0]);
  assign q0x = signed'(seg_i.q0_x[CB-1:0]);
  assign q0y = signed'(seg_i.q0_y[CB-1:0]);
  assign q1x = signed'(seg_i.q1_x[CB-1:0]);
  assign q1y = signed'(seg_i.q1_y[CB-1:0]);

  logic signed [DW-1:0] d1x_1_q, d1y_1_q, d2x_1_q, d2y_1_q, ex_1_q, ey_1_q;
  logic [CB-1:0]        bx_1_q, by_1_q;

  always_ff @(posedge clk_i) begin
    d1x_1_q <= DW'(p1x) - DW'(p0x);
    d1y_1_q <= DW'(p1y) - DW'(p0y);
    d2x_1_q <= DW'(q1x) - DW'(q0x);
    d2y_1_q <= DW'(q1y) - DW'(q0y);
    ex_1_q  <= DW'(q0x) - DW'(p0x);
    ey_1_q  <= DW'(q0y) - DW'(p0y);
    bx_1_q  <= p0x;
    by_1_q  <= p0y;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the six products of the three cross products
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] c_a_2_q, c_b_2_q, s_a_2_q, s_b_2_q, t_a_2_q, t_b_2_q;
  logic signed [DW-1:0] d1x_2_q, d1y_2_q;
  logic [CB-1:0]        bx_2_q, by_2_q;

  always_ff @(posedge clk_i) begin
    c_a_2_q <= PW'(d1x_1_q) * PW'(d2y_1_q);
    c_b_2_q <= PW'(d1y_1_q) * PW'(d2x_1_q);
    s_a_2_q <= PW'(ex_1_q) * PW'(d2y_1_q);
    s_b_2_q <= PW'(ey_1_q) * PW'(d2x_1_q);
    t_a_2_q <= PW'(ex_1_q) * PW'(d1y_1_q);
    t_b_2_q <= PW'(ey_1_q) * PW'(d1x_1_q);
    d1x_2_q <= d1x_1_q;
    d1y_2_q <= d1y_1_q;
    bx_2_q  <= bx_1_q;
    by_2_q  <= by_1_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: c = d1 x d2, s = e x d2, t = e x d1 (exact, never overflow CW)
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] c_3_q, s_3_q, t_3_q;
  logic signed [DW-1:0] d1x_3_q, d1y_3_q;
  logic [CB-1:0]        bx_3_q, by_3_q;

  always_ff @(posedge clk_i) begin
    c_3_q   <= CW'(c_a_2_q - c_b_2_q);
    s_3_q   <= CW'(s_a_2_q - s_b_2_q);
    t_3_q   <= CW'(t_a_2_q - t_b_2_q);
    d1x_3_q <= d1x_2_q;
    d1y_3_q <= d1y_2_q;
    bx_3_q  <= bx_2_q;
    by_3_q  <= by_2_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: sign-aware range test of s/c and t/c, magnitudes and signs
  // ---------------------------------------------------------------------------
  logic                 s_in, t_in, hit_3;
  logic signed [CW-1:0] s_abs, c_abs;
  logic signed [DW-1:0] d1x_abs, d1y_abs;

  always_comb begin
    if (c_3_q[CW-1]) begin
      s_in = (s_3_q <= 0) && (s_3_q >= c_3_q);
      t_in = (t_3_q <= 0) && (t_3_q >= c_3_q);
    end else begin
      s_in = (s_3_q >= 0) && (s_3_q <= c_3_q);
      t_in = (t_3_q >= 0) && (t_3_q <= c_3_q);
    end
    hit_3   = (c_3_q != 0) && s_in && t_in;
    s_abs   = s_3_q[CW-1] ? -s_3_q : s_3_q;
    c_abs   = c_3_q[CW-1] ? -c_3_q : c_3_q;
    d1x_abs = d1x_3_q[DW-1] ? -d1x_3_q : d1x_3_q;
    d1y_abs = d1y_3_q[DW-1] ? -d1y_3_q : d1y_3_q;
  end

  logic [MW-1:0] smag_4_q, cmag_4_q;
  logic [CB-1:0] dxm_4_q, dym_4_q;
  side_t         side_4_q;

  always_ff @(posedge clk_i) begin
    smag_4_q        <= s_abs[MW-1:0];
    cmag_4_q        <= c_abs[MW-1:0];
    dxm_4_q         <= d1x_abs[CB-1:0];
    dym_4_q         <= d1y_abs[CB-1:0];
    side_4_q.hit    <= hit_3;
    side_4_q.neg_x  <= d1x_3_q[DW-1] ^ s_3_q[CW-1] ^ c_3_q[CW-1];
    side_4_q.neg_y  <= d1y_3_q[DW-1] ^ s_3_q[CW-1] ^ c_3_q[CW-1];
    side_4_q.base_x <= bx_3_q;
    side_4_q.base_y <= by_3_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: |d1| * |s| split into two partial products per axis
  // ---------------------------------------------------------------------------
  logic [CB+SL-1:0] px_lo_5_q, py_lo_5_q;
  logic [CB+SH-1:0] px_hi_5_q, py_hi_5_q;
  logic [MW-1:0]    cmag_5_q;
  side_t            side_5_q;

  always_ff @(posedge clk_i) begin
    px_lo_5_q <= (CB+SL)'(dxm_4_q) * (CB+SL)'(smag_4_q[SL-1:0]);
    px_hi_5_q <= (CB+SH)'(dxm_4_q) * (CB+SH)'(smag_4_q[MW-1:SL]);
    py_lo_5_q <= (CB+SL)'(dym_4_q) * (CB+SL)'(smag_4_q[SL-1:0]);
    py_hi_5_q <= (CB+SH)'(dym_4_q) * (CB+SH)'(smag_4_q[MW-1:SL]);
    cmag_5_q  <= cmag_4_q;
    side_5_q  <= side_4_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 6: join the partial products into the full numerator
  // ---------------------------------------------------------------------------
  logic [NW-1:0] numx_6_q, numy_6_q;
  logic [MW-1:0] cmag_6_q;
  side_t         side_6_q;

  always_ff @(posedge clk_i) begin
    numx_6_q <= {px_hi_5_q, {SL{1'b0}}} + NW'(px_lo_5_q);
    numy_6_q <= {py_hi_5_q, {SL{1'b0}}} + NW'(py_lo_5_q);
    cmag_6_q <= cmag_5_q;
    side_6_q <= side_5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], accept};
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: trunc(|d1| * |s| / |c|) per axis; sideband delayed to match
  // ---------------------------------------------------------------------------
  logic [CB-1:0] quo_x, quo_y;

  ssi_div u_div_x (
    .clk_i (clk_i),
    .num_i (numx_6_q),
    .den_i (cmag_6_q),
    .quo_o (quo_x)
  );

  ssi_div u_div_y (
    .clk_i (clk_i),
    .num_i (numy_6_q),
    .den_i (cmag_6_q),
    .quo_o (quo_y)
  );

  side_t                           side_q [ssi_pkg::DIV_STAGES];
  logic [ssi_pkg::DIV_STAGES-1:0]  dvld_q;

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_6_q;
    for (int k = 1; k < ssi_pkg::DIV_STAGES; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q <= '0;
    end else begin
      dvld_q <= {dvld_q[ssi_pkg::DIV_STAGES-2:0], vld_q[5]};
    end
  end

  // ---------------------------------------------------------------------------
  // Output word: P0 +/- quotient, zero on a miss; held for one cycle only
  // ---------------------------------------------------------------------------
  side_t         side_e;
  logic [CB-1:0] pt_x, pt_y;

  assign side_e = side_q[ssi_pkg::DIV_STAGES-1];
  assign pt_x   = side_e.base_x + (side_e.neg_x ? -quo_x : quo_x);
  assign pt_y   = side_e.base_y + (side_e.neg_y ? -quo_y : quo_y);

  logic          done_q;
  ssi_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dvld_q[ssi_pkg::DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.hit     <= side_e.hit;
    res_q.point_x <= side_e.hit ? ssi_pkg::FIELD_W'(signed'(pt_x)) : '0;
    res_q.point_y <= side_e.hit ? ssi_pkg::FIELD_W'(signed'(pt_y)) : '0;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ----- hdl/ssi_checker.sv -----
`timescale 1ns / 1ps

module ssi_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input logic          done_o,
  input ssi_pkg::res_t result_o
);

  // fully pipelined: a request is never refused
  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

  // every word out was caused by a word in, a fixed depth earlier
  a_fixed_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, ssi_pkg::RES_LAT))
    else $error("result without matching request");

  // a miss carries a zero point
  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.hit) |-> (result_o.point_x == 0 && result_o.point_y == 0))
    else $error("nonzero point on miss");

endmodule

bind segment_segment_intersect ssi_checker u_ssi_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .result_o (result_o)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

// Segment pair intersection: words stream in under a start/busy handshake,
// one result word per input word comes back marked by done_o.
// Expectations are worked out at full width (128 bits) when a word is
// accepted and matched, in order, against the result words.
module testbench;

  typedef logic signed [127:0] wide_t;

  // one queued input word plus the idle cycles that follow it
  typedef struct packed {
    ssi_pkg::seg_t word;
    logic [7:0]    gap;
  } pair_job_t;

  localparam int unsigned RANDOM_PAIRS = 800;
  localparam int          ONE          = 65536;          // 1.0 in Q16.16
  localparam logic signed [31:0] CMAX  = 32'sh7fff_ffff;
  localparam logic signed [31:0] CMIN  = 32'sh8000_0000;

  logic           clk_i   = 1'b0;
  logic           rst_ni  = 1'b0;
  logic           start_i = 1'b0;
  ssi_pkg::seg_t  seg_i   = '0;
  logic           busy_o;
  logic           done_o;
  ssi_pkg::res_t  result_o;

  pair_job_t     pending_pairs[$];
  ssi_pkg::res_t expected_points[$];
  int unsigned   gap_left   = 0;
  int unsigned   words_seen = 0;
  int unsigned   errors     = 0;

  segment_segment_intersect dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .seg_i    (seg_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Only the low COORD_BITS of a field count; sign-extend from there.
  function automatic wide_t widen(logic [ssi_pkg::FIELD_W-1:0] raw);
    return {{(128-ssi_pkg::COORD_BITS){raw[ssi_pkg::COORD_BITS-1]}},
            raw[ssi_pkg::COORD_BITS-1:0]};
  endfunction

  // n/c within [0,1], decided without division (c is non-zero)
  function automatic logic in_unit(wide_t n, wide_t c);
    wide_t zero = '0;
    if (c < zero) return (n <= zero) && (n >= c);
    return (n >= zero) && (n <= c);
  endfunction

  function automatic ssi_pkg::res_t predict_intersection(ssi_pkg::seg_t w);
    wide_t         p0x, p0y, p1x, p1y, q0x, q0y, q1x, q1y;
    wide_t         d1x, d1y, d2x, d2y, ex, ey, cr, sn, tn;
    ssi_pkg::res_t r;
    p0x = widen(w.p0_x);  p0y = widen(w.p0_y);
    p1x = widen(w.p1_x);  p1y = widen(w.p1_y);
    q0x = widen(w.q0_x);  q0y = widen(w.q0_y);
    q1x = widen(w.q1_x);  q1y = widen(w.q1_y);
    d1x = p1x - p0x;  d1y = p1y - p0y;
    d2x = q1x - q0x;  d2y = q1y - q0y;
    ex  = q0x - p0x;  ey  = q0y - p0y;
    // products stay below 2^67, the lerp numerator below 2^100: all exact
    cr = d1x * d2y - d1y * d2x;
    sn = ex * d2y - ey * d2x;
    tn = ex * d1y - ey * d1x;
    r = '0;
    if (cr != 0 && in_unit(sn, cr) && in_unit(tn, cr)) begin
      r.hit = 1'b1;
      // signed division truncates toward zero, as the block does
      r.point_x = ssi_pkg::FIELD_W'(p0x + (d1x * sn) / cr);
      r.point_y = ssi_pkg::FIELD_W'(p0y + (d1y * sn) / cr);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // random value sign-extended from its low k bits (1 <= k <= 32)
  function automatic logic signed [31:0] rand_coord(int unsigned k);
    logic signed [31:0] v;
    v = $urandom;
    return (v <<< (32 - k)) >>> (32 - k);
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic logic [7:0] pick_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return 8'd0;
    if (r < 9) return 8'($urandom_range(1, 3));
    return 8'($urandom_range(4, 40));
  endfunction

  task automatic add_pair(input logic signed [31:0] ax, ay, bx, by, cx, cy, dx, dy,
                          input logic [7:0] gap);
    pair_job_t job;
    job.word = '{ax, ay, bx, by, cx, cy, dx, dy};
    job.gap  = gap;
    pending_pairs.push_back(job);
  endtask

  function automatic ssi_pkg::seg_t make_random_pair();
    int unsigned        kind, k;
    logic signed [31:0] mx, my, vx, vy;
    ssi_pkg::seg_t      w;
    kind = $urandom_range(0, 99);
    k    = $urandom_range(1, 32);
    w = '{rand_coord(k), rand_coord(k), rand_coord(k), rand_coord(k),
          rand_coord(k), rand_coord(k), rand_coord(k), rand_coord(k)};
    if (kind < 55) begin
      // free placement at a shared scale; hits come often enough
    end else if (kind < 72) begin
      // Q crosses P through its midpoint: a hit is nearly certain
      k = $urandom_range(2, 30);
      w.p0_x = rand_coord(k);  w.p0_y = rand_coord(k);
      w.p1_x = rand_coord(k);  w.p1_y = rand_coord(k);
      mx = (w.p0_x + w.p1_x) >>> 1;
      my = (w.p0_y + w.p1_y) >>> 1;
      vx = rand_coord(k);
      vy = rand_coord(k);
      w.q0_x = mx + vx;  w.q0_y = my + vy;
      w.q1_x = mx - vx;  w.q1_y = my - vy;
    end else if (kind < 82) begin
      // endpoint touch: Q starts or ends on an end of P
      if ($urandom_range(0, 1)) begin
        w.q0_x = w.p1_x;  w.q0_y = w.p1_y;
      end else begin
        w.q1_x = w.p0_x;  w.q1_y = w.p0_y;
      end
    end else if (kind < 91) begin
      // parallel, or collinear with Q starting at the end of P
      k = $urandom_range(1, 29);
      w.p0_x = rand_coord(k);  w.p0_y = rand_coord(k);
      w.p1_x = rand_coord(k);  w.p1_y = rand_coord(k);
      w.q0_x = rand_coord(k);  w.q0_y = rand_coord(k);
      if ($urandom_range(0, 1)) begin
        w.q0_x = w.p1_x;  w.q0_y = w.p1_y;
      end
      if ($urandom_range(0, 1)) begin
        w.q1_x = w.q0_x + (w.p1_x - w.p0_x);
        w.q1_y = w.q0_y + (w.p1_y - w.p0_y);
      end else begin
        w.q1_x = w.q0_x - (w.p1_x - w.p0_x);
        w.q1_y = w.q0_y - (w.p1_y - w.p0_y);
      end
    end else if (kind < 95) begin
      // zero-length segment on either side
      if ($urandom_range(0, 1)) begin
        w.p1_x = w.p0_x;  w.p1_y = w.p0_y;
      end else begin
        w.q1_x = w.q0_x;  w.q1_y = w.q0_y;
      end
    end else begin
      // raw full-width noise, every bit of every field toggles
      w = '{$urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: a word is taken at an edge where start_i is high and busy_o low
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_proc
    pair_job_t job;
    if (rst_ni) begin
      if (start_i && !busy_o) expected_points.push_back(predict_intersection(seg_i));

      if (start_i && busy_o) begin
        // word not taken yet: hold it steady
      end else if (gap_left != 0) begin
        start_i  <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_pairs.size() != 0) begin
        job = pending_pairs.pop_front();
        seg_i    <= job.word;
        start_i  <= 1'b1;          // stays high across back-to-back words
        gap_left <= job.gap;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: done_o marks each result word for exactly one cycle
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : check_proc
    ssi_pkg::res_t want;
    if (rst_ni && done_o) begin
      words_seen <= words_seen + 1;
      if (expected_points.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10)
          $display("ERROR word %0d: unexpected result hit=%0b x=%0d y=%0d",
                   words_seen, result_o.hit, result_o.point_x, result_o.point_y);
      end else begin
        want = expected_points.pop_front();
        if (result_o.hit !== want.hit || result_o.point_x !== want.point_x ||
            result_o.point_y !== want.point_y) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("ERROR word %0d: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                     words_seen, want.hit, want.point_x, want.point_y,
                     result_o.hit, result_o.point_x, result_o.point_y);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin : stim_proc
    pair_job_t   job;
    int unsigned made, run, style, i;

    // Directed words, coordinates in units of 1.0 unless noted
    add_pair(0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE, 0, pick_gap());        // plain X
    add_pair(0, 0, 2*ONE, 2*ONE, 2*ONE, 0, 0, 2*ONE, pick_gap());        // Q reversed: cross positive
    add_pair(0, 0, 2*ONE, 0, 0, ONE, 2*ONE, ONE, pick_gap());            // parallel
    add_pair(0, 0, 3*ONE, 0, ONE, 0, 4*ONE, 0, pick_gap());              // collinear overlap
    add_pair(ONE, ONE, ONE, ONE, 0, 0, 2*ONE, 2*ONE, pick_gap());        // P has no length
    add_pair(0, 0, 2*ONE, 2*ONE, ONE, ONE, ONE, ONE, pick_gap());        // Q has no length
    add_pair(0, 0, 2*ONE, 0, 0, -ONE, 0, ONE, pick_gap());               // touch at P start
    add_pair(0, 0, 2*ONE, 0, 2*ONE, -ONE, 2*ONE, ONE, pick_gap());       // touch at P end
    add_pair(0, 0, 2*ONE, 0, ONE, 0, ONE, 2*ONE, pick_gap());            // Q starts on P
    add_pair(0, 0, 2*ONE, 0, ONE, 2*ONE, ONE, 0, pick_gap());            // Q ends on P
    add_pair(0, 0, 2*ONE, 0, 2*ONE, 0, 2*ONE, 2*ONE, pick_gap());        // corner to corner
    add_pair(0, 0, ONE, 0, 2*ONE, -ONE, 2*ONE, ONE, pick_gap());         // miss past P end
    add_pair(0, 0, ONE, 0, -ONE, -ONE, -ONE, ONE, pick_gap());           // miss before P start
    add_pair(0, 0, 2*ONE, 0, ONE, ONE, ONE, 3*ONE, pick_gap());          // miss along Q
    add_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, pick_gap()); // full-span X
    add_pair(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, pick_gap()); // same, reversed
    add_pair(CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX, pick_gap());            // full-span plus
    add_pair(CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, pick_gap()); // far parallel
    add_pair(0, 0, 0, 0, 0, 0, 0, 0, pick_gap());                        // all zero
    add_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, pick_gap());
    add_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, pick_gap());
    // raw LSB values: the point falls between codes, truncation shows
    add_pair(0, 0, 1, 1, 0, 1, 1, 0, pick_gap());
    add_pair(0, 0, -1, -1, 0, -1, -1, 0, pick_gap());
    add_pair(0, 0, -7, -5, -7, 0, 0, -5, pick_gap());

    // Random words in runs: some back to back, some with gaps
    made = 0;
    while (made < RANDOM_PAIRS) begin
      run   = $urandom_range(10, 60);
      style = $urandom_range(0, 2);
      for (i = 0; i < run; i++) begin
        job.word = make_random_pair();
        job.gap  = (style == 0) ? 8'd0 : pick_gap();
        pending_pairs.push_back(job);
      end
      made += run;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every word to be taken, then for the pipe to drain
    while (pending_pairs.size() != 0 || start_i) @(posedge clk_i);
    for (i = 0; i < 4 * ssi_pkg::RES_LAT && expected_points.size() != 0; i++)
      @(posedge clk_i);
    repeat (ssi_pkg::RES_LAT + 8) @(posedge clk_i);

    if (expected_points.size() != 0) begin
      $display("ERROR: %0d result words never arrived", expected_points.size());
      errors += expected_points.size();
    end
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin : guard_proc
    #(2_000_000);
    $display("ERROR: run timed out");
    $display("Mismatches found");
    $finish;
  end

endmodule
